### rtl/filtered_hysteresis_thermostat_unit_macros.svh
// Assertion macros shared by the thermostat unit RTL.
`ifndef FILTERED_HYSTERESIS_THERMOSTAT_UNIT_MACROS_SVH
`define FILTERED_HYSTERESIS_THERMOSTAT_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define FHT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that a condition implies a consequence in the following cycle.
`define FHT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/fht_pkg.sv
// Shared types and constants of the filtered hysteresis thermostat unit.
`timescale 1ns / 1ps
`default_nettype none

package fht_pkg;

   // Filtered values: unsigned, 8 fraction bits
   localparam int VAL_W     = 20;
   localparam int FRAC_BITS = 8;
   localparam int ALPHA_W   = 9;

   localparam logic [VAL_W-1:0]   VAL_MAX    = {VAL_W{1'b1}};
   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1 << FRAC_BITS);
   localparam int                 ROUND_HALF = 1 << (FRAC_BITS - 1);

   // Result word: filtered value, drive power, cool select, thermostat state
   localparam int RSP_DATA_W = 24;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd26;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_MODE   = 3'd0,
      CSR_ALPHA_Q8      = 3'd1,
      CSR_HEAT_ON_BELOW = 3'd2,
      CSR_HEAT_OFF_AT   = 3'd3,
      CSR_COOL_ON_ABOVE = 3'd4,
      CSR_COOL_OFF_AT   = 3'd5
   } csr_index_type;

   typedef enum logic {
      FILTER_MEAN = 1'b0,
      FILTER_EMA  = 1'b1
   } filter_mode_type;

   typedef struct packed {
      filter_mode_type      mode;
      logic [ALPHA_W-1:0]   alpha;
   } filter_cfg_type;

   typedef struct packed {
      logic [VAL_W-1:0] heat_on_below;
      logic [VAL_W-1:0] heat_off_at;
      logic [VAL_W-1:0] cool_on_above;
      logic [VAL_W-1:0] cool_off_at;
   } thresh_type;

endpackage

`default_nettype wire

### rtl/fht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fht_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/fht_filter.sv
// Filter stage: ring-buffer running sum and exponential average update.
`timescale 1ns / 1ps
`default_nettype none
`include "filtered_hysteresis_thermostat_unit_macros.svh"

module fht_filter #(
   parameter int DEPTH       = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire fht_pkg::filter_cfg_type                 cfg,
   input  wire logic                                    in_valid,
   input  wire logic [SAMPLE_BITS-1:0]                  in_sample,
   output logic                                         in_ready,
   output logic                                         flt_valid,
   output fht_pkg::filter_mode_type                     flt_mode,
   output logic [SAMPLE_BITS+$clog2(DEPTH)-1:0]         flt_sum,
   output logic [fht_pkg::VAL_W-1:0]                    flt_ema,
   input  wire logic                                    dn_ready
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SUM_W  = SAMPLE_BITS + PTR_W;
   localparam int XW     = SAMPLE_BITS + fht_pkg::FRAC_BITS;
   localparam int ACC_W  = fht_pkg::ALPHA_W + fht_pkg::VAL_W + 2;
   localparam int HI_W   = fht_pkg::VAL_W + fht_pkg::FRAC_BITS;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(DEPTH * ((1 << SAMPLE_BITS) - 1));

   logic                              load;
   logic                              fire;
   logic                              ring_we;

   logic [PTR_W-1:0]                  ptr_ff, ptr_in, ptr_next;
   logic                              filled_ff, filled_in;
   logic [SUM_W-1:0]                  sum_ff, sum_in, sum_upd;
   logic [fht_pkg::VAL_W-1:0]         smooth_ff, smooth_in, smooth_upd;

   logic [SAMPLE_BITS-1:0]            ram_rdata;
   logic [SAMPLE_BITS-1:0]            oldest;

   logic [fht_pkg::ALPHA_W-1:0]       alpha_sat;
   logic [XW-1:0]                     x_wide;
   logic [31:0]                       x_ext;
   logic [fht_pkg::VAL_W-1:0]         x_val;
   logic signed [fht_pkg::VAL_W:0]    diff;
   logic signed [ACC_W-1:0]           prod;
   logic signed [ACC_W-1:0]           acc;

   logic                              flt_valid_ff;
   fht_pkg::filter_mode_type          flt_mode_ff;
   logic [SUM_W-1:0]                  flt_sum_ff;
   logic [fht_pkg::VAL_W-1:0]         flt_ema_ff;

   // Stage handshake: load when empty or when the next stage takes the item
   assign load     = !flt_valid_ff || dn_ready;
   assign fire     = in_valid && load;
   assign in_ready = load;
   assign ring_we  = fire && (cfg.mode == fht_pkg::FILTER_MEAN);

   // Ring holds the last DEPTH samples; read data always shows the pointer's entry
   fht_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ptr_ff),
      .wdata (in_sample),
      .raddr (ptr_in),
      .rdata (ram_rdata)
   );

   // Entries are written in pointer order, so the pointer's entry is live once wrapped
   assign oldest   = filled_ff ? ram_rdata : '0;
   assign sum_upd  = sum_ff - SUM_W'(oldest) + SUM_W'(in_sample);
   assign ptr_next = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;

   // Exponential average: s + a*(x - s), rounded half up
   always_comb begin
      alpha_sat = (cfg.alpha > fht_pkg::ALPHA_ONE) ? fht_pkg::ALPHA_ONE : cfg.alpha;
      x_wide    = {in_sample, {fht_pkg::FRAC_BITS{1'b0}}};
      x_ext     = 32'(x_wide);
      x_val     = (x_ext > 32'(fht_pkg::VAL_MAX)) ? fht_pkg::VAL_MAX
                                                   : x_ext[fht_pkg::VAL_W-1:0];
      diff      = $signed({1'b0, x_val}) - $signed({1'b0, smooth_ff});
      prod      = $signed({1'b0, alpha_sat}) * diff;
      acc       = $signed({{(ACC_W-HI_W){1'b0}}, smooth_ff, {fht_pkg::FRAC_BITS{1'b0}}})
                  + prod + $signed(ACC_W'(fht_pkg::ROUND_HALF));
      if (acc[ACC_W-1:HI_W] != '0) begin
         smooth_upd = fht_pkg::VAL_MAX;
      end else begin
         smooth_upd = acc[HI_W-1:fht_pkg::FRAC_BITS];
      end
   end

   // Advance only the state of the selected filter
   always_comb begin
      ptr_in    = ptr_ff;
      filled_in = filled_ff;
      sum_in    = sum_ff;
      smooth_in = smooth_ff;
      if (fire) begin
         case (cfg.mode)
            fht_pkg::FILTER_MEAN: begin
               ptr_in = ptr_next;
               sum_in = sum_upd;
               if (ptr_ff == PTR_LAST) begin
                  filled_in = 1'b1;
               end
            end
            fht_pkg::FILTER_EMA: begin
               smooth_in = smooth_upd;
            end
            default: begin
               smooth_in = smooth_ff;
            end
         endcase
      end
   end

   // Hold filter state and the stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         filled_ff    <= 1'b0;
         sum_ff       <= '0;
         smooth_ff    <= '0;
         flt_valid_ff <= 1'b0;
      end else begin
         ptr_ff    <= ptr_in;
         filled_ff <= filled_in;
         sum_ff    <= sum_in;
         smooth_ff <= smooth_in;
         if (load) begin
            flt_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         flt_mode_ff <= cfg.mode;
         flt_sum_ff  <= sum_upd;
         flt_ema_ff  <= smooth_upd;
      end
   end

   assign flt_valid = flt_valid_ff;
   assign flt_mode  = flt_mode_ff;
   assign flt_sum   = flt_sum_ff;
   assign flt_ema   = flt_ema_ff;

   // The ring is never read at the entry written in the same cycle
   `FHT_ASSERT_IMPLY(a_ring_no_collision, clock, reset, ring_we, ptr_in != ptr_ff)
   // A wrap of the pointer marks the whole ring as written
   `FHT_ASSERT_NEXT(a_ring_filled_on_wrap, clock, reset, ring_we && (ptr_ff == PTR_LAST), filled_ff)
   // The running sum never exceeds DEPTH full-scale samples
   `FHT_ASSERT_IMPLY(a_sum_in_range, clock, reset, ring_we, sum_upd <= SUM_MAX)

endmodule

`default_nettype wire

### rtl/fht_scale.sv
// Scale stage: floor mean of the ring sum by reciprocal multiply, filter select.
`timescale 1ns / 1ps
`default_nettype none

module fht_scale #(
   parameter int DEPTH       = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    flt_valid,
   input  wire fht_pkg::filter_mode_type                flt_mode,
   input  wire logic [SAMPLE_BITS+$clog2(DEPTH)-1:0]    flt_sum,
   input  wire logic [fht_pkg::VAL_W-1:0]               flt_ema,
   output logic                                         in_ready,
   output logic                                         scl_valid,
   output logic [fht_pkg::VAL_W-1:0]                    scl_value,
   input  wire logic                                    dn_ready
);

   localparam int L_BITS = $clog2(DEPTH);
   localparam int SUM_W  = SAMPLE_BITS + L_BITS;
   localparam int SHIFT  = SUM_W + L_BITS;
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam int MEAN_W = SAMPLE_BITS + fht_pkg::FRAC_BITS;
   // ceil(2^SHIFT / DEPTH) gives the exact floor quotient for every SUM_W-bit sum
   localparam logic [63:0]      RECIP64 = ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
   localparam logic [SUM_W:0]   RECIP   = RECIP64[SUM_W:0];

   logic                         load;
   logic [PROD_W-1:0]            prod;
   logic [SAMPLE_BITS-1:0]       quot;
   logic [MEAN_W-1:0]            mean_wide;
   logic [31:0]                  mean_ext;
   logic [fht_pkg::VAL_W-1:0]    mean_val;
   logic [fht_pkg::VAL_W-1:0]    value_in;

   logic                         scl_valid_ff;
   logic [fht_pkg::VAL_W-1:0]    scl_value_ff;

   assign load     = !scl_valid_ff || dn_ready;
   assign in_ready = load;

   // Divide the sum by DEPTH, move to 8 fraction bits, clamp to the value range, pick the filter
   always_comb begin
      prod      = PROD_W'(flt_sum) * PROD_W'(RECIP);
      quot      = prod[SHIFT +: SAMPLE_BITS];
      mean_wide = {quot, {fht_pkg::FRAC_BITS{1'b0}}};
      mean_ext  = 32'(mean_wide);
      mean_val  = (mean_ext > 32'(fht_pkg::VAL_MAX)) ? fht_pkg::VAL_MAX
                                                     : mean_ext[fht_pkg::VAL_W-1:0];
      case (flt_mode)
         fht_pkg::FILTER_MEAN: value_in = mean_val;
         fht_pkg::FILTER_EMA:  value_in = flt_ema;
         default:              value_in = flt_ema;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_valid_ff <= 1'b0;
      end else if (load) begin
         scl_valid_ff <= flt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && flt_valid) begin
         scl_value_ff <= value_in;
      end
   end

   assign scl_valid = scl_valid_ff;
   assign scl_value = scl_value_ff;

endmodule

`default_nettype wire

### rtl/fht_decide.sv
// Thermostat stage: batch counter, hysteresis state machine and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "filtered_hysteresis_thermostat_unit_macros.svh"

module fht_decide #(
   parameter int DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fht_pkg::thresh_type          thresh,
   input  wire logic                         scl_valid,
   input  wire logic [fht_pkg::VAL_W-1:0]    scl_value,
   output logic                              in_ready,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [fht_pkg::VAL_W-1:0]         rsp_value,
   output logic                              rsp_decided,
   output logic                              rsp_power,
   output logic                              rsp_cool,
   output logic [1:0]                        rsp_state
);

   localparam int BW = $clog2(DEPTH);
   localparam logic [BW-1:0] BATCH_LAST = BW'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_HEAT = 2'd1,
      ST_COOL = 2'd2
   } thermo_state_type;

   logic                        load;
   logic                        fire;
   logic                        batch_last;

   logic                        out_valid_ff;
   logic [fht_pkg::VAL_W-1:0]   value_ff;
   logic                        decided_ff;
   logic [BW-1:0]               batch_ff, batch_in;
   thermo_state_type            state_ff, state_in;
   logic                        power_ff, power_in;
   logic                        cool_ff, cool_in;

   assign load       = !out_valid_ff || rsp_ready;
   assign fire       = scl_valid && load;
   assign in_ready   = load;
   assign batch_last = (batch_ff == BATCH_LAST);

   // Drive follows the state before the move; in idle a cooling test wins
   always_comb begin
      state_in = state_ff;
      power_in = power_ff;
      cool_in  = cool_ff;
      batch_in = batch_ff;
      if (fire) begin
         batch_in = batch_last ? '0 : batch_ff + 1'b1;
         if (batch_last) begin
            case (state_ff)
               ST_HEAT: begin
                  power_in = 1'b1;
                  cool_in  = 1'b0;
                  if (scl_value >= thresh.heat_off_at) begin
                     state_in = ST_IDLE;
                  end
               end
               ST_COOL: begin
                  power_in = 1'b1;
                  cool_in  = 1'b1;
                  if (scl_value <= thresh.cool_off_at) begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  power_in = 1'b0;
                  cool_in  = 1'b0;
                  state_in = ST_IDLE;
                  if (scl_value < thresh.heat_on_below) begin
                     state_in = ST_HEAT;
                  end
                  if (scl_value > thresh.cool_on_above) begin
                     state_in = ST_COOL;
                  end
               end
            endcase
         end
      end
   end

   // Hold thermostat state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         batch_ff     <= '0;
         state_ff     <= ST_IDLE;
         power_ff     <= 1'b0;
         cool_ff      <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= scl_valid;
         end
         if (fire) begin
            value_ff   <= scl_value;
            decided_ff <= batch_last;
         end
         batch_ff <= batch_in;
         state_ff <= state_in;
         power_ff <= power_in;
         cool_ff  <= cool_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_value   = value_ff;
   assign rsp_decided = decided_ff;
   assign rsp_power   = power_ff;
   assign rsp_cool    = cool_ff;
   assign rsp_state   = state_ff;

   // The cooling path is selected only with power on
   `FHT_ASSERT_IMPLY(a_cool_needs_power, clock, reset, cool_ff, power_ff)
   // The thermostat moves only when a batch closes
   `FHT_ASSERT_NEXT(a_state_holds_mid_batch, clock, reset, fire && !batch_last, $stable(state_ff))
   // A decision taken from idle switches the drive off
   `FHT_ASSERT_NEXT(a_idle_drive_off, clock, reset, fire && batch_last && (state_ff == ST_IDLE), !power_ff && !cool_ff)

endmodule

`default_nettype wire

### rtl/filtered_hysteresis_thermostat_unit.sv
// Top level of the filtered hysteresis thermostat unit.
//
//  Channel   Direction  Signals                                    Content
//  req       in         req_tvalid/req_tready/req_tdata            one sensor sample
//  rsp       out        rsp_tvalid/rsp_tready/rsp_tdata/rsp_tlast  filtered value, drive, state
//  csr       in         csr_valid/csr_ready/csr_index/csr_data     register writes
//
//  One request per clock unless a result stalls; a taken request passes filter, scale and result.
//  Four register stages (input, filter, scale, result); the filter loop closes in the filter stage.
//  Reset clears the ring at once through a fill flag, so requests are taken right after reset.
//  Each stage loads when empty or drained, so while a result stalls requests enter until all are full.
`timescale 1ns / 1ps
`default_nettype none

module filtered_hysteresis_thermostat_unit #(
   parameter int DEPTH       = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request: [SAMPLE_BITS-1:0] sample, zero fill above
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   // result: [19:0] filtered_value, [20] drive_power, [21] cool_select, [23:22] mode_state
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [fht_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fht_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fht_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic                                   csr_write;
   fht_pkg::filter_mode_type               mode_ff;
   logic [fht_pkg::ALPHA_W-1:0]            alpha_ff;
   logic [fht_pkg::VAL_W-1:0]              heat_on_ff;
   logic [fht_pkg::VAL_W-1:0]              heat_off_ff;
   logic [fht_pkg::VAL_W-1:0]              cool_on_ff;
   logic [fht_pkg::VAL_W-1:0]              cool_off_ff;
   fht_pkg::filter_cfg_type                filter_cfg;
   fht_pkg::thresh_type                    thresh;

   logic                                   in_load;
   logic                                   in_valid_ff;
   logic [SAMPLE_BITS-1:0]                 sample_ff;

   logic                                   flt_in_ready;
   logic                                   flt_valid;
   fht_pkg::filter_mode_type               flt_mode;
   logic [SAMPLE_BITS+$clog2(DEPTH)-1:0]   flt_sum;
   logic [fht_pkg::VAL_W-1:0]              flt_ema;

   logic                                   scl_in_ready;
   logic                                   scl_valid;
   logic [fht_pkg::VAL_W-1:0]              scl_value;

   logic                                   dec_in_ready;
   logic [fht_pkg::VAL_W-1:0]              rsp_value;
   logic                                   rsp_power;
   logic                                   rsp_cool;
   logic [1:0]                             rsp_state;

   // Register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= fht_pkg::FILTER_EMA;
         alpha_ff    <= fht_pkg::ALPHA_RESET;
         heat_on_ff  <= '0;
         heat_off_ff <= '0;
         cool_on_ff  <= fht_pkg::VAL_MAX;
         cool_off_ff <= fht_pkg::VAL_MAX;
      end else if (csr_write) begin
         case (fht_pkg::csr_index_type'(csr_index))
            fht_pkg::CSR_FILTER_MODE:   mode_ff     <= fht_pkg::filter_mode_type'(csr_data[0]);
            fht_pkg::CSR_ALPHA_Q8:      alpha_ff    <= csr_data[fht_pkg::ALPHA_W-1:0];
            fht_pkg::CSR_HEAT_ON_BELOW: heat_on_ff  <= csr_data[fht_pkg::VAL_W-1:0];
            fht_pkg::CSR_HEAT_OFF_AT:   heat_off_ff <= csr_data[fht_pkg::VAL_W-1:0];
            fht_pkg::CSR_COOL_ON_ABOVE: cool_on_ff  <= csr_data[fht_pkg::VAL_W-1:0];
            fht_pkg::CSR_COOL_OFF_AT:   cool_off_ff <= csr_data[fht_pkg::VAL_W-1:0];
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   assign filter_cfg = '{mode: mode_ff, alpha: alpha_ff};
   assign thresh     = '{heat_on_below: heat_on_ff, heat_off_at: heat_off_ff,
                         cool_on_above: cool_on_ff, cool_off_at: cool_off_ff};

   // Input register: take a request when empty or when the filter takes the held one
   assign in_load    = !in_valid_ff || flt_in_ready;
   assign req_tready = in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   fht_filter #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (filter_cfg),
      .in_valid  (in_valid_ff),
      .in_sample (sample_ff),
      .in_ready  (flt_in_ready),
      .flt_valid (flt_valid),
      .flt_mode  (flt_mode),
      .flt_sum   (flt_sum),
      .flt_ema   (flt_ema),
      .dn_ready  (scl_in_ready)
   );

   fht_scale #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .flt_valid (flt_valid),
      .flt_mode  (flt_mode),
      .flt_sum   (flt_sum),
      .flt_ema   (flt_ema),
      .in_ready  (scl_in_ready),
      .scl_valid (scl_valid),
      .scl_value (scl_value),
      .dn_ready  (dec_in_ready)
   );

   fht_decide #(
      .DEPTH (DEPTH)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .thresh      (thresh),
      .scl_valid   (scl_valid),
      .scl_value   (scl_value),
      .in_ready    (dec_in_ready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_decided (rsp_tlast),
      .rsp_power   (rsp_power),
      .rsp_cool    (rsp_cool),
      .rsp_state   (rsp_state)
   );

   // Pack the result word, lowest field first
   assign rsp_tdata = {rsp_state, rsp_cool, rsp_power, rsp_value};

endmodule

`default_nettype wire
